// ===== rtl/pafs_pkg.sv =====
// ----------------------------------------------------------------------------
// pafs_pkg
// Shared types, constants and the CORDIC angle table for the pilot-aided
// frequency and phase synchronizer.
// ----------------------------------------------------------------------------
package pafs_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;
  // CORDIC datapath: symbol scaled by 2^16 or correlation scaled by 2^8,
  // plus growth from the gain and the first quadrant fold
  localparam int CW           = 48;
  localparam int ZW           = 34;

  localparam logic [14:0] INV_GAIN_Q15     = 15'd19898;
  localparam logic [4:0]  PILOT_MAX        = 5'd31;
  localparam logic [15:0] FRAME_SYMBOLS_RST = 16'd33282;

  localparam int MUL_B_W  = 24;
  localparam int MUL_STEPS = 24;
  localparam int DIV_STEPS = 64;

  typedef enum logic {
    CORDIC_ROTATE,
    CORDIC_VECTOR
  } cordic_mode_t;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_t;

  // one queued symbol with its position and pilot class
  typedef struct packed {
    logic signed [15:0] i;
    logic signed [15:0] q;
    logic [15:0]        n;
    logic [15:0]        len;
    logic               pil_in;
    logic               pil_first;
    logic               pil_last;
    logic               frame_end;
  } pafs_item_t;

  typedef struct packed {
    logic frame_loaded;
    logic busy;
  } pafs_status_t;

  // atan(2^-k) in units of 2^-32 turn
  function automatic logic [31:0] turn_atan(input logic [STEP_W-1:0] k);
    logic [31:0] a;
    case (k)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/pilot_aided_freq_phase_sync.sv =====
// ----------------------------------------------------------------------------
// pilot_aided_freq_phase_sync
// Pilot-aided fine frequency and phase synchronizer with a double-buffered
// frame store; releases each earlier-frame symbol derotated by the fit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_i, in_q
//  out     | output    | out_valid/out_stall| out_i, out_q, out_frame_last,
//          |           |                    | out_est_freq, out_est_phase
//  cfg     | input     | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
//  Each word passes through the back end; one that releases a derotated
//  symbol uses the 24-step shared CORDIC, and the end of each kept pilot block
//  adds the vectoring CORDIC and a 24-step serial multiply.
//  At frame end the fit runs on the serial multiply/divide unit. A two-word
//  queue keeps accepting meanwhile until it is full.
//  Reset is synchronous; no frame is loaded after reset, so the first frame
//  releases nothing. A stalled output word holds the back end at its release.
// ----------------------------------------------------------------------------
module pilot_aided_freq_phase_sync #(
  parameter int MAX_FRAME_SYMBOLS  = 33282,
  parameter int FIRST_PILOT_SYMBOL = 1530,
  parameter int PILOT_PERIOD       = 1476,
  parameter int PILOT_LENGTH       = 36
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_i,
  input  logic signed [15:0] in_q,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_i,
  output logic signed [15:0] out_q,
  output logic               out_frame_last,
  output logic signed [31:0] out_est_freq,
  output logic [31:0]        out_est_phase,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pafs_pkg::*;

  localparam logic REG_FRAME_SYMBOLS = 1'b0;

  logic [15:0]  frame_symbols_r;
  pafs_item_t   q_item;
  logic         q_valid, q_pop;
  pafs_status_t back_status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAME_SYMBOLS) ? {16'b0, frame_symbols_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_symbols_r <= FRAME_SYMBOLS_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_FRAME_SYMBOLS) begin
      frame_symbols_r <= pwdata[15:0];
    end
  end

  pafs_front #(
    .MAX_FRAME_SYMBOLS  (MAX_FRAME_SYMBOLS),
    .FIRST_PILOT_SYMBOL (FIRST_PILOT_SYMBOL),
    .PILOT_PERIOD       (PILOT_PERIOD),
    .PILOT_LENGTH       (PILOT_LENGTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_i          (in_i),
    .in_q          (in_q),
    .frame_symbols (frame_symbols_r),
    .q_item        (q_item),
    .q_valid       (q_valid),
    .q_pop         (q_pop)
  );

  pafs_back #(
    .MAX_FRAME_SYMBOLS (MAX_FRAME_SYMBOLS),
    .PILOT_PERIOD      (PILOT_PERIOD),
    .PILOT_LENGTH      (PILOT_LENGTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_item         (q_item),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_i          (out_i),
    .out_q          (out_q),
    .out_frame_last (out_frame_last),
    .out_est_freq   (out_est_freq),
    .out_est_phase  (out_est_phase),
    .status         (back_status)
  );

`ifndef ASSERT_OFF
  a_out_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> back_status.frame_loaded)
    else $error("output word without a loaded frame");

  a_queue_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  a_idle_no_new_output: assert property (@(posedge clk) disable iff (!rst_n)
    (!back_status.busy && !out_valid) |=> !out_valid)
    else $error("output word appeared while back end idle");
`endif

endmodule

// ===== rtl/pafs_front.sv =====
// ----------------------------------------------------------------------------
// pafs_front
// Accepts symbols, tracks the position in the frame and the pilot grid, and
// queues each word with its class for the back end.
// ----------------------------------------------------------------------------
module pafs_front #(
  parameter int MAX_FRAME_SYMBOLS  = 33282,
  parameter int FIRST_PILOT_SYMBOL = 1530,
  parameter int PILOT_PERIOD       = 1476,
  parameter int PILOT_LENGTH       = 36
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   in_i,
  input  logic signed [15:0]   in_q,
  input  logic [15:0]          frame_symbols,
  output pafs_pkg::pafs_item_t q_item,
  output logic                 q_valid,
  input  logic                 q_pop
);
  import pafs_pkg::*;

  localparam int EFF   = (PILOT_LENGTH < PILOT_PERIOD) ? PILOT_LENGTH : PILOT_PERIOD;
  localparam int OFF_W = $clog2(PILOT_PERIOD);

  pafs_item_t       fifo_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;
  logic [15:0]      n_r;
  logic [OFF_W-1:0] off_r;

  logic [15:0] len_c;
  logic        started_c, pil_in_c, frame_end_c, push_c;
  pafs_item_t  item_c;

  always_comb begin
    if (frame_symbols == 16'd0) begin
      len_c = 16'd1;
    end else if (frame_symbols > 16'(MAX_FRAME_SYMBOLS)) begin
      len_c = 16'(MAX_FRAME_SYMBOLS);
    end else begin
      len_c = frame_symbols;
    end
  end

  assign started_c   = n_r >= 16'(FIRST_PILOT_SYMBOL);
  assign pil_in_c    = started_c && ({1'b0, off_r} < (OFF_W+1)'(EFF));
  assign frame_end_c = ({1'b0, n_r} + 17'd1) >= {1'b0, len_c};
  assign in_stall    = cnt_r == 2'd2;
  assign push_c      = in_valid && !in_stall;

  always_comb begin
    item_c.i         = in_i;
    item_c.q         = in_q;
    item_c.n         = n_r;
    item_c.len       = len_c;
    item_c.pil_in    = pil_in_c;
    item_c.pil_first = pil_in_c && (off_r == '0);
    item_c.pil_last  = pil_in_c && (off_r == OFF_W'(EFF - 1));
    item_c.frame_end = frame_end_c;
  end

  assign q_valid = cnt_r != 2'd0;
  assign q_item  = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      n_r      <= 16'd0;
      off_r    <= '0;
    end else begin
      if (push_c) begin
        wr_ptr_r <= ~wr_ptr_r;
        if (frame_end_c) begin
          n_r   <= 16'd0;
          off_r <= '0;
        end else begin
          n_r <= n_r + 16'd1;
          // advance the pilot grid once the first pilot is reached
          if (!started_c || off_r == OFF_W'(PILOT_PERIOD - 1)) begin
            off_r <= '0;
          end else begin
            off_r <= off_r + OFF_W'(1);
          end
        end
      end
      if (q_pop && q_valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push_c} - {1'b0, q_pop && q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (push_c) begin
      fifo_r[wr_ptr_r] <= item_c;
    end
  end

endmodule

// ===== rtl/pafs_cordic.sv =====
// ----------------------------------------------------------------------------
// pafs_cordic
// Iterative CORDIC, one micro-rotation per cycle, in rotating or vectoring
// mode. Angles are in units of 2^-32 turn.
// ----------------------------------------------------------------------------
module pafs_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  pafs_pkg::cordic_mode_t        mode,
  input  logic signed [pafs_pkg::CW-1:0] x0,
  input  logic signed [pafs_pkg::CW-1:0] y0,
  input  logic [31:0]                   ang,
  output logic                          done,
  output logic signed [pafs_pkg::CW-1:0] x,
  output logic signed [pafs_pkg::CW-1:0] y,
  output logic signed [pafs_pkg::ZW-1:0] z
);
  import pafs_pkg::*;

  logic              busy_r, done_r;
  logic [STEP_W-1:0] k_r;
  cordic_mode_t      mode_r;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;

  logic                 rot_flip_c;
  logic [31:0]          ang_c;
  logic signed [CW-1:0] x_init_c, y_init_c, dx_c, dy_c;
  logic signed [ZW-1:0] z_init_c, a_c;
  logic                 neg_dir_c;

  always_comb begin
    rot_flip_c = (ang - 32'h4000_0000) < 32'h8000_0000;
    ang_c      = rot_flip_c ? (ang - 32'h8000_0000) : ang;
    if (mode == CORDIC_ROTATE) begin
      x_init_c = rot_flip_c ? -x0 : x0;
      y_init_c = rot_flip_c ? -y0 : y0;
      z_init_c = ZW'($signed(ang_c));
    end else begin
      // fold the left half plane over
      x_init_c = x0[CW-1] ? -x0 : x0;
      y_init_c = x0[CW-1] ? -y0 : y0;
      z_init_c = x0[CW-1] ? $signed({2'b00, 32'h8000_0000}) : '0;
    end
  end

  always_comb begin
    dx_c      = y_r >>> k_r;
    dy_c      = x_r >>> k_r;
    a_c       = $signed({2'b00, turn_atan(k_r)});
    neg_dir_c = (mode_r == CORDIC_ROTATE) ? !z_r[ZW-1] : y_r[CW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (busy_r) begin
        k_r <= k_r + STEP_W'(1);
        if (k_r == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode;
      x_r    <= x_init_c;
      y_r    <= y_init_c;
      z_r    <= z_init_c;
    end else if (busy_r) begin
      if (neg_dir_c) begin
        x_r <= x_r - dx_c;
        y_r <= y_r + dy_c;
        z_r <= z_r - a_c;
      end else begin
        x_r <= x_r + dx_c;
        y_r <= y_r - dy_c;
        z_r <= z_r + a_c;
      end
    end
  end

  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;

endmodule

// ===== rtl/pafs_muldiv.sv =====
// ----------------------------------------------------------------------------
// pafs_muldiv
// Shared serial arithmetic: shift-add multiply (64 by 24 bits, result modulo
// 2^64) and restoring unsigned 64-bit divide, one bit per cycle.
// ----------------------------------------------------------------------------
module pafs_muldiv (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  pafs_pkg::md_op_t                op,
  input  logic [63:0]                     a,
  input  logic [pafs_pkg::MUL_B_W-1:0]    b,
  input  logic [63:0]                     d,
  output logic                            done,
  output logic [63:0]                     res
);
  import pafs_pkg::*;

  logic         busy_r, done_r;
  logic [5:0]   cnt_r;
  md_op_t       op_r;
  logic [63:0]  acc_r, a_r, d_r;
  logic [MUL_B_W-1:0] b_r;
  logic [64:0]  rem_r;

  logic [64:0]  rem_sh_c;
  logic         fits_c;
  logic         last_c;

  assign rem_sh_c = {rem_r[63:0], a_r[63]};
  assign fits_c   = rem_sh_c >= {1'b0, d_r};
  assign last_c   = (op_r == MD_MUL) ? (cnt_r == 6'(MUL_STEPS - 1))
                                     : (cnt_r == 6'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (last_c) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= op;
      acc_r <= 64'd0;
      a_r   <= a;
      b_r   <= b;
      d_r   <= d;
      rem_r <= 65'd0;
    end else if (busy_r) begin
      if (op_r == MD_MUL) begin
        if (b_r[0]) begin
          acc_r <= acc_r + a_r;
        end
        a_r <= {a_r[62:0], 1'b0};
        b_r <= b_r >> 1;
      end else begin
        rem_r <= fits_c ? (rem_sh_c - {1'b0, d_r}) : rem_sh_c;
        a_r   <= {a_r[62:0], fits_c};
      end
    end
  end

  assign done = done_r;
  assign res  = (op_r == MD_MUL) ? acc_r : a_r;

endmodule

// ===== rtl/pafs_back.sv =====
// ----------------------------------------------------------------------------
// pafs_back
// Takes queued symbols one at a time: stores them in the double-buffered
// frame store, derotates the earlier frame, estimates pilot phases and fits
// frequency and phase at each frame end.
// ----------------------------------------------------------------------------
module pafs_back #(
  parameter int MAX_FRAME_SYMBOLS = 33282,
  parameter int PILOT_PERIOD      = 1476,
  parameter int PILOT_LENGTH      = 36
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pafs_pkg::pafs_item_t   q_item,
  input  logic                   q_valid,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [15:0]     out_i,
  output logic signed [15:0]     out_q,
  output logic                   out_frame_last,
  output logic signed [31:0]     out_est_freq,
  output logic [31:0]            out_est_phase,
  output pafs_pkg::pafs_status_t status
);
  import pafs_pkg::*;

  localparam int EFF    = (PILOT_LENGTH < PILOT_PERIOD) ? PILOT_LENGTH : PILOT_PERIOD;
  localparam int CORR_W = 18 + $clog2(EFF);
  localparam int AW     = $clog2(2 * MAX_FRAME_SYMBOLS);

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_ROT_GO, S_ROT_WAIT, S_FIN, S_PILOT, S_VEC_WAIT, S_TY_WAIT,
    S_END, S_FIT0, S_F1, S_F2, S_F3, S_F4, S_F5, S_PH0, S_PH1, S_PH2, S_SWAP
  } state_t;

  state_t      state_r;
  pafs_item_t  it_r;
  logic        bank_r, out_ok_r;
  logic [15:0] out_len_r;
  logic signed [CORR_W-1:0] corr_i_r, corr_q_r;
  logic [31:0] prev_ph_r;
  logic signed [7:0] turns_r;
  logic [4:0]  pcnt_r;
  logic [23:0] st_r;
  logic signed [47:0] sy_r;
  logic [63:0] sty_r;
  logic [39:0] stt_r;
  logic [31:0] freq_r, phase_r, fn_r;
  logic [31:0] mem_q_r;
  logic signed [63:0] fin_i_r, fin_q_r;
  logic        vec_zero_r;
  logic [16:0] t_r;
  logic [63:0] m1_r, num_r, den_r;
  logic signed [31:0] f_fit_r;
  logic signed [63:0] fst_r;
  logic        phn_neg_r;
  logic        out_valid_r, out_last_r;
  logic signed [15:0] out_i_r, out_q_r;
  logic [31:0] out_freq_r, out_phase_r;

  logic [31:0] mem [2*MAX_FRAME_SYMBOLS];

  // datapath helpers
  logic        do_out_c;
  logic        fin_fire_c;
  logic [AW-1:0] wr_addr_c, rd_addr_c;
  logic signed [CORR_W-1:0] ci_c, cq_c;
  logic [16:0] t_c;
  logic [31:0] ph_c;
  logic signed [32:0] d_c;
  logic signed [7:0]  turns_nxt;
  logic signed [40:0] y_c;
  logic [33:0] tt_c;
  logic [47:0] st2_c;
  logic [63:0] mag_num_c, phn_c, mag_phn_c;
  logic signed [63:0] fst_c;
  logic signed [63:0] rnd_i_c, rnd_q_c;
  logic        vec_go_c;

  // CORDIC and arithmetic unit hookup
  logic          cor_start, cor_done;
  cordic_mode_t  cor_mode;
  logic signed [CW-1:0] cor_x0, cor_y0, cor_x, cor_y;
  logic signed [ZW-1:0] cor_z;
  logic [31:0]   cor_ang;
  logic          md_start, md_done;
  md_op_t        md_op;
  logic [63:0]   md_a, md_d, md_res;
  logic [MUL_B_W-1:0] md_b;

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v >>> 31;
    if (s > 64'sd32767) begin
      return 16'h7FFF;
    end else if (s < -64'sd32768) begin
      return 16'h8000;
    end
    return s[15:0];
  endfunction

  assign do_out_c   = out_ok_r && (it_r.n < out_len_r);
  assign fin_fire_c = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign wr_addr_c  = bank_r ? (AW'(MAX_FRAME_SYMBOLS) + AW'(it_r.n)) : AW'(it_r.n);
  assign rd_addr_c  = bank_r ? AW'(it_r.n) : (AW'(MAX_FRAME_SYMBOLS) + AW'(it_r.n));

  always_comb begin
    ci_c = (it_r.pil_first ? CORR_W'(0) : corr_i_r) + CORR_W'(it_r.i) + CORR_W'(it_r.q);
    cq_c = (it_r.pil_first ? CORR_W'(0) : corr_q_r) + CORR_W'(it_r.q) - CORR_W'(it_r.i);
    t_c  = {1'b0, it_r.n} - 17'(EFF - 1) + 17'(EFF / 2);
    ph_c = vec_zero_r ? 32'd0 : cor_z[31:0];
    d_c  = $signed({1'b0, ph_c}) - $signed({1'b0, prev_ph_r});
    turns_nxt = turns_r;
    // unwrap by whole turns on a jump beyond half a turn
    if (pcnt_r != 5'd0) begin
      if (d_c > 33'sd2147483648) begin
        turns_nxt = turns_r + 8'sd1;
      end else if (d_c < -33'sd2147483648) begin
        turns_nxt = turns_r - 8'sd1;
      end
    end
    y_c   = $signed({9'b0, ph_c}) - $signed({turns_nxt[7], turns_nxt, 32'b0});
    tt_c  = 34'(t_r) * 34'(t_r);
    st2_c = 48'(st_r) * 48'(st_r);
    mag_num_c = num_r[63] ? (64'd0 - num_r) : num_r;
    fst_c = 64'(f_fit_r) * 64'($signed({1'b0, st_r}));
    phn_c = 64'(sy_r) - fst_r;
    mag_phn_c = phn_c[63] ? (64'd0 - phn_c) : phn_c;
    rnd_i_c = fin_i_r + 64'sd1073741824;
    rnd_q_c = fin_q_r + 64'sd1073741824;
    vec_go_c = (state_r == S_PILOT) && it_r.pil_in && it_r.pil_last && (pcnt_r != PILOT_MAX);
  end

  always_comb begin
    cor_start = (state_r == S_ROT_GO) || vec_go_c;
    cor_mode  = (state_r == S_ROT_GO) ? CORDIC_ROTATE : CORDIC_VECTOR;
    if (state_r == S_ROT_GO) begin
      cor_x0 = CW'($signed(mem_q_r[15:0])) <<< 16;
      cor_y0 = CW'($signed(mem_q_r[31:16])) <<< 16;
    end else begin
      cor_x0 = CW'(ci_c) <<< 8;
      cor_y0 = CW'(cq_c) <<< 8;
    end
    cor_ang = 32'd0 - (fn_r + phase_r);
  end

  always_comb begin
    md_start = 1'b0;
    md_op    = MD_MUL;
    md_a     = 64'd0;
    md_b     = '0;
    md_d     = 64'd1;
    case (state_r)
      S_VEC_WAIT: begin
        md_start = cor_done;
        md_a     = 64'(y_c);
        md_b     = MUL_B_W'(t_r);
      end
      S_FIT0: begin
        md_start = pcnt_r >= 5'd2;
        md_a     = sty_r;
        md_b     = MUL_B_W'(pcnt_r);
      end
      S_F1: begin
        md_start = md_done;
        md_a     = 64'(sy_r);
        md_b     = st_r;
      end
      S_F2: begin
        md_start = md_done;
        md_a     = {24'b0, stt_r};
        md_b     = MUL_B_W'(pcnt_r);
      end
      S_F4: begin
        md_start = $signed(den_r) > 64'sd0;
        md_op    = MD_DIV;
        md_a     = mag_num_c + (den_r >> 1);
        md_d     = den_r;
      end
      S_PH1: begin
        md_start = 1'b1;
        md_op    = MD_DIV;
        md_a     = mag_phn_c + 64'(pcnt_r >> 1);
        md_d     = 64'(pcnt_r);
      end
      default: begin
        md_start = 1'b0;
      end
    endcase
  end

  assign q_pop = (state_r == S_IDLE) && q_valid;

  pafs_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .mode  (cor_mode),
    .x0    (cor_x0),
    .y0    (cor_y0),
    .ang   (cor_ang),
    .done  (cor_done),
    .x     (cor_x),
    .y     (cor_y),
    .z     (cor_z)
  );

  pafs_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .op    (md_op),
    .a     (md_a),
    .b     (md_b),
    .d     (md_d),
    .done  (md_done),
    .res   (md_res)
  );

  // frame store: write the new symbol, read the earlier frame's one
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      mem[wr_addr_c] <= {it_r.q, it_r.i};
      mem_q_r        <= mem[rd_addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bank_r      <= 1'b0;
      out_ok_r    <= 1'b0;
      out_len_r   <= 16'd0;
      corr_i_r    <= '0;
      corr_q_r    <= '0;
      prev_ph_r   <= 32'd0;
      turns_r     <= 8'sd0;
      pcnt_r      <= 5'd0;
      st_r        <= 24'd0;
      sy_r        <= 48'sd0;
      sty_r       <= 64'd0;
      stt_r       <= 40'd0;
      freq_r      <= 32'd0;
      phase_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_fire_c) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            it_r    <= q_item;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          fn_r    <= 32'(freq_r * 32'(it_r.n));
          state_r <= do_out_c ? S_ROT_GO : S_PILOT;
        end
        S_ROT_GO: begin
          state_r <= S_ROT_WAIT;
        end
        S_ROT_WAIT: begin
          if (cor_done) begin
            fin_i_r <= 64'(cor_x) * 64'($signed({1'b0, INV_GAIN_Q15}));
            fin_q_r <= 64'(cor_y) * 64'($signed({1'b0, INV_GAIN_Q15}));
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (fin_fire_c) begin
            out_i_r     <= sat16(rnd_i_c);
            out_q_r     <= sat16(rnd_q_c);
            out_last_r  <= it_r.n == (out_len_r - 16'd1);
            out_freq_r  <= freq_r;
            out_phase_r <= phase_r;
            state_r     <= S_PILOT;
          end
        end
        S_PILOT: begin
          state_r <= S_END;
          if (it_r.pil_in) begin
            if (it_r.pil_last) begin
              corr_i_r <= '0;
              corr_q_r <= '0;
              if (vec_go_c) begin
                vec_zero_r <= (ci_c == '0) && (cq_c == '0);
                t_r        <= t_c;
                state_r    <= S_VEC_WAIT;
              end
            end else begin
              corr_i_r <= ci_c;
              corr_q_r <= cq_c;
            end
          end
        end
        S_VEC_WAIT: begin
          if (cor_done) begin
            prev_ph_r <= ph_c;
            turns_r   <= turns_nxt;
            st_r      <= st_r + 24'(t_r);
            sy_r      <= sy_r + 48'(y_c);
            stt_r     <= stt_r + 40'(tt_c);
            state_r   <= S_TY_WAIT;
          end
        end
        S_TY_WAIT: begin
          if (md_done) begin
            sty_r   <= sty_r + md_res;
            pcnt_r  <= pcnt_r + 5'd1;
            state_r <= S_END;
          end
        end
        S_END: begin
          state_r <= it_r.frame_end ? S_FIT0 : S_IDLE;
        end
        S_FIT0: begin
          f_fit_r <= 32'sd0;
          if (pcnt_r == 5'd0) begin
            freq_r  <= 32'd0;
            phase_r <= 32'd0;
            state_r <= S_SWAP;
          end else begin
            state_r <= (pcnt_r >= 5'd2) ? S_F1 : S_PH0;
          end
        end
        S_F1: begin
          if (md_done) begin
            m1_r    <= md_res;
            state_r <= S_F2;
          end
        end
        S_F2: begin
          if (md_done) begin
            num_r   <= m1_r - md_res;
            state_r <= S_F3;
          end
        end
        S_F3: begin
          if (md_done) begin
            den_r   <= md_res - {16'b0, st2_c};
            state_r <= S_F4;
          end
        end
        S_F4: begin
          state_r <= ($signed(den_r) > 64'sd0) ? S_F5 : S_PH0;
        end
        S_F5: begin
          if (md_done) begin
            if (num_r[63]) begin
              f_fit_r <= (md_res > 64'h8000_0000) ? 32'sh8000_0000
                                                  : $signed(32'd0 - md_res[31:0]);
            end else begin
              f_fit_r <= (md_res > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                  : $signed(md_res[31:0]);
            end
            state_r <= S_PH0;
          end
        end
        S_PH0: begin
          fst_r   <= fst_c;
          state_r <= S_PH1;
        end
        S_PH1: begin
          phn_neg_r <= phn_c[63];
          state_r   <= S_PH2;
        end
        S_PH2: begin
          if (md_done) begin
            phase_r <= phn_neg_r ? (32'd0 - md_res[31:0]) : md_res[31:0];
            freq_r  <= f_fit_r;
            state_r <= S_SWAP;
          end
        end
        S_SWAP: begin
          out_len_r <= it_r.len;
          out_ok_r  <= 1'b1;
          bank_r    <= ~bank_r;
          corr_i_r  <= '0;
          corr_q_r  <= '0;
          prev_ph_r <= 32'd0;
          turns_r   <= 8'sd0;
          pcnt_r    <= 5'd0;
          st_r      <= 24'd0;
          sy_r      <= 48'sd0;
          sty_r     <= 64'd0;
          stt_r     <= 40'd0;
          state_r   <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_i          = out_i_r;
  assign out_q          = out_q_r;
  assign out_frame_last = out_last_r;
  assign out_est_freq   = $signed(out_freq_r);
  assign out_est_phase  = out_phase_r;

  assign status.frame_loaded = out_ok_r;
  assign status.busy         = state_r != S_IDLE;

endmodule
